>>> hw/rtl/life_grid_generation_engine_top_macros.svh
// Assertion macros shared by the life grid engine modules.
`ifndef LIFE_GRID_GENERATION_ENGINE_TOP_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define LGGE_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LGGE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lgge_pkg.sv
// Package with types and constants of the life grid engine.
`timescale 1ns / 1ps
`default_nettype none
package lgge_pkg;

   localparam int GRID_SIZE_DEF = 32;
   localparam int ASZ_W         = 6;
   localparam logic [ASZ_W-1:0] ASZ_RST = 6'd25;
   localparam int KIND_W        = 2;
   localparam int COORD_W       = 5;
   localparam int CMP_W         = 8;
   localparam int NCNT_W        = 4;
   localparam logic [NCNT_W-1:0] BIRTH_CNT = 4'd3;
   localparam logic [NCNT_W-1:0] KEEP_CNT  = 4'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_STEP   = 2'd1,
      KIND_READ   = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MODIFY,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic capture;
      logic acc_read;
      logic acc_modify;
      logic step_init;
      logic step_run;
      logic rsp_fire;
   } cmd_type;

   typedef struct packed {
      logic step_item;
      logic access_ok;
      logic size_zero;
      logic step_done;
   } sts_type;

endpackage
`default_nettype wire

>>> hw/rtl/life_grid_generation_engine_top.sv
// Top level of the life grid engine: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Conway B3/S23 engine on a bounded square grid, all cells dead after reset.
// An item is taken at a clock edge with start high and busy low; its one
// result shows on the rsp_ ports for exactly one cycle with rsp_valid high
// and cannot be held off, so sample it then. A write or read in range reads
// its row, and a write stores the changed row back in the modify state. An
// out-of-range access, unused kind or step at active size zero is answered
// from decode. The active size is clipped to GRID_SIZE. The grid sits
// in a one-row-wide memory with one read and one write port, and a step
// sweeps it one row per cycle through three row buffers. A new item may be
// started in the cycle its predecessor's result is shown. Write the
// active_size register only while busy is low.
module life_grid_generation_engine_top #(
   parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lgge_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [lgge_pkg::COORD_W-1:0]  req_column,
   input  wire logic [lgge_pkg::COORD_W-1:0]  req_row,
   input  wire logic                          req_cell_value,
   output logic                               rsp_valid,
   output logic                               rsp_cell_state,
   output logic                               rsp_status,
   input  wire logic                          csr_write_en,
   input  wire logic [lgge_pkg::ASZ_W-1:0]    csr_write_data
);

   lgge_pkg::cmd_type cmd;
   lgge_pkg::sts_type sts;

   lgge_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   lgge_dp #(
      .GRID_SIZE (GRID_SIZE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_cell_value (req_cell_value),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_cell_state (rsp_cell_state),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

>>> hw/rtl/lgge_ctrl.sv
// Controller state machine of the life grid engine.
`timescale 1ns / 1ps
`default_nettype none
`include "life_grid_generation_engine_top_macros.svh"
module lgge_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output lgge_pkg::cmd_type     cmd,
   input  wire lgge_pkg::sts_type sts
);

   lgge_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgge_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         lgge_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = lgge_pkg::ST_DECODE;
            end
         end
         lgge_pkg::ST_DECODE: begin
            if (sts.access_ok) begin
               cmd.acc_read = 1'b1;
               state_in     = lgge_pkg::ST_MODIFY;
            end else if (sts.step_item && !sts.size_zero) begin
               cmd.step_init = 1'b1;
               state_in      = lgge_pkg::ST_STEP;
            end else begin
               cmd.rsp_fire = 1'b1;
               state_in     = lgge_pkg::ST_IDLE;
            end
         end
         lgge_pkg::ST_MODIFY: begin
            cmd.acc_modify = 1'b1;
            cmd.rsp_fire   = 1'b1;
            state_in       = lgge_pkg::ST_IDLE;
         end
         lgge_pkg::ST_STEP: begin
            cmd.step_run = 1'b1;
            if (sts.step_done) begin
               cmd.rsp_fire = 1'b1;
               state_in     = lgge_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lgge_pkg::ST_IDLE;
         end
      endcase
   end

   `LGGE_ASSERT_NEXT(a_start_decodes, clock, reset, (state_ff == lgge_pkg::ST_IDLE) && start, state_ff == lgge_pkg::ST_DECODE, "accepted item did not enter decode")
   `LGGE_ASSERT_NEXT(a_fire_to_idle, clock, reset, cmd.rsp_fire, state_ff == lgge_pkg::ST_IDLE, "controller not idle after response")
   `LGGE_ASSERT_NEXT(a_step_stays, clock, reset, (state_ff == lgge_pkg::ST_STEP) && !sts.step_done, state_ff == lgge_pkg::ST_STEP, "generation sweep left early")

endmodule
`default_nettype wire

>>> hw/rtl/lgge_dp.sv
// Datapath of the life grid engine: row memory, sweep buffers, rule logic, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "life_grid_generation_engine_top_macros.svh"
module lgge_dp #(
   parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lgge_pkg::cmd_type                cmd,
   output lgge_pkg::sts_type                     sts,
   input  wire logic [lgge_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [lgge_pkg::COORD_W-1:0]     req_column,
   input  wire logic [lgge_pkg::COORD_W-1:0]     req_row,
   input  wire logic                             req_cell_value,
   input  wire logic                             csr_write_en,
   input  wire logic [lgge_pkg::ASZ_W-1:0]       csr_write_data,
   output logic                                  rsp_valid,
   output logic                                  rsp_cell_state,
   output logic                                  rsp_status
);

   localparam int ROW_W = $clog2(GRID_SIZE);
   localparam int CNT_W = $clog2(GRID_SIZE + 2);

   lgge_pkg::kind_type               item_kind_ff;
   logic [lgge_pkg::COORD_W-1:0]     item_col_ff, item_row_ff;
   logic                             item_val_ff;
   logic [lgge_pkg::ASZ_W-1:0]       active_size_ff;

   logic [GRID_SIZE-1:0] cell_mem_ff [GRID_SIZE];
   logic [GRID_SIZE-1:0] row_vld_ff;
   logic [GRID_SIZE-1:0] rd_raw_ff;
   logic                 rd_vld_ff;

   logic [CNT_W-1:0]     step_k_ff;
   logic [GRID_SIZE-1:0] up_ff, mid_ff;

   logic                 rsp_valid_ff, rsp_cell_state_ff, rsp_status_ff;
   logic                 rsp_cell_state_in, rsp_status_in;

   logic [CNT_W-1:0]     size_n;
   logic                 in_range, step_done, write_step;
   logic [ROW_W-1:0]     row_idx, col_idx, rd_addr, wr_addr;
   logic                 rd_en, wr_en;
   logic [GRID_SIZE-1:0] rd_row, mod_row, wr_data, mask;
   logic [GRID_SIZE-1:0] up_m, mid_m, dn_m, next_row;
   logic [GRID_SIZE-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= lgge_pkg::ASZ_RST;
      end else if (csr_write_en) begin
         active_size_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_kind_ff <= lgge_pkg::kind_type'(req_kind);
         item_col_ff  <= req_column;
         item_row_ff  <= req_row;
         item_val_ff  <= req_cell_value;
      end
   end

   always_comb begin
      if (lgge_pkg::CMP_W'(active_size_ff) > lgge_pkg::CMP_W'(GRID_SIZE)) begin
         size_n = CNT_W'(GRID_SIZE);
      end else begin
         size_n = CNT_W'(active_size_ff);
      end
   end

   assign in_range = (lgge_pkg::CMP_W'(item_col_ff) < lgge_pkg::CMP_W'(size_n)) &&
                     (lgge_pkg::CMP_W'(item_row_ff) < lgge_pkg::CMP_W'(size_n));
   assign row_idx  = ROW_W'(item_row_ff);
   assign col_idx  = ROW_W'(item_col_ff);
   assign step_done = (step_k_ff == size_n + CNT_W'(1));

   assign sts.step_item = (item_kind_ff == lgge_pkg::KIND_STEP);
   assign sts.access_ok = ((item_kind_ff == lgge_pkg::KIND_WRITE) ||
                           (item_kind_ff == lgge_pkg::KIND_READ)) && in_range;
   assign sts.size_zero = (size_n == '0);
   assign sts.step_done = step_done;

   assign write_step = cmd.step_run && (step_k_ff >= CNT_W'(2));
   assign rd_en   = cmd.acc_read || (cmd.step_run && (step_k_ff < size_n));
   assign rd_addr = cmd.step_run ? step_k_ff[ROW_W-1:0] : row_idx;
   assign wr_en   = (cmd.acc_modify && (item_kind_ff == lgge_pkg::KIND_WRITE)) || write_step;
   assign wr_addr = cmd.step_run ? ROW_W'(step_k_ff - CNT_W'(2)) : row_idx;
   assign wr_data = cmd.step_run ? next_row : mod_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= cell_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_vld_ff ? rd_raw_ff : '0;

   always_comb begin
      mod_row          = rd_row;
      mod_row[col_idx] = item_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_k_ff <= '0;
      end else if (cmd.step_init) begin
         step_k_ff <= '0;
      end else if (cmd.step_run) begin
         step_k_ff <= step_k_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_init) begin
         up_ff  <= '0;
         mid_ff <= '0;
      end else if (cmd.step_run && (step_k_ff != '0)) begin
         up_ff  <= mid_ff;
         mid_ff <= rd_row;
      end
   end

   for (genvar c = 0; c < GRID_SIZE; c++) begin : g_mask
      assign mask[c] = (CNT_W'(c) < size_n);
   end

   assign up_m  = up_ff & mask;
   assign mid_m = mid_ff & mask;
   assign dn_m  = step_done ? '0 : (rd_row & mask);
   assign up_l  = up_m << 1;
   assign up_r  = up_m >> 1;
   assign mid_l = mid_m << 1;
   assign mid_r = mid_m >> 1;
   assign dn_l  = dn_m << 1;
   assign dn_r  = dn_m >> 1;

   for (genvar c = 0; c < GRID_SIZE; c++) begin : g_rule
      logic [lgge_pkg::NCNT_W-1:0] ncnt;
      logic                        live;
      assign ncnt = lgge_pkg::NCNT_W'(up_l[c])  + lgge_pkg::NCNT_W'(up_m[c]) +
                    lgge_pkg::NCNT_W'(up_r[c])  + lgge_pkg::NCNT_W'(mid_l[c]) +
                    lgge_pkg::NCNT_W'(mid_r[c]) + lgge_pkg::NCNT_W'(dn_l[c]) +
                    lgge_pkg::NCNT_W'(dn_m[c])  + lgge_pkg::NCNT_W'(dn_r[c]);
      assign live = (ncnt == lgge_pkg::BIRTH_CNT) ||
                    (mid_m[c] && (ncnt == lgge_pkg::KEEP_CNT));
      assign next_row[c] = mask[c] ? live : mid_ff[c];
   end

   always_comb begin
      case (item_kind_ff)
         lgge_pkg::KIND_WRITE: begin
            rsp_cell_state_in = item_val_ff && in_range;
            rsp_status_in     = !in_range;
         end
         lgge_pkg::KIND_READ: begin
            rsp_cell_state_in = rd_row[col_idx] && in_range;
            rsp_status_in     = !in_range;
         end
         lgge_pkg::KIND_STEP: begin
            rsp_cell_state_in = 1'b0;
            rsp_status_in     = 1'b0;
         end
         default: begin
            rsp_cell_state_in = 1'b0;
            rsp_status_in     = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_cell_state_ff <= rsp_cell_state_in;
         rsp_status_ff     <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_cell_state_ff;
   assign rsp_status     = rsp_status_ff;

   `LGGE_ASSERT_NEXT(a_rsp_follows_fire, clock, reset, cmd.rsp_fire, rsp_valid_ff, "response strobe missing")
   `LGGE_ASSERT_HOLDS(a_no_addr_clash, clock, reset, rd_en && wr_en, rd_addr != wr_addr, "row read and write hit one address")
   `LGGE_ASSERT_HOLDS(a_step_bound, clock, reset, cmd.step_run, step_k_ff <= size_n + CNT_W'(1), "sweep counter past last row")

endmodule
`default_nettype wire
